[design/lcx_pkg.sv]
// Shared types, constants and the ratio^1.4 table for the two-channel lux calculator.
`default_nettype none
package lcx_pkg;

  localparam int POWER_TABLE_DEPTH = 64;
  localparam int LUX_FRACTION_BITS = 16;

  localparam int CNT_W   = 16;
  localparam int LUX_W   = 27;
  localparam int REG_W   = 3;
  localparam int Q_W     = CNT_W + 1;               // Q16 ratio, at most 0.5 in region 0 for nonzero broadband
  localparam int TBL_W   = 17;                      // table entries stay at or below 2^16
  localparam int SEG_W   = $clog2(POWER_TABLE_DEPTH + 1);
  localparam int M_VAL   = 2 * POWER_TABLE_DEPTH;   // nodes per unit of ratio
  localparam int M_W     = $clog2(M_VAL + 1);
  localparam int POS_W   = Q_W + M_W;
  localparam int COEF_W  = 29;
  localparam int BBP_W   = CNT_W + TBL_W;
  localparam int PROD_W  = 48;
  localparam int SHIFT   = 32 - LUX_FRACTION_BITS;
  localparam int DIV_CELLS = Q_W;

  localparam logic [LUX_W-1:0] LUX_MAX = {LUX_W{1'b1}};

  // Q32 coefficients
  localparam logic [COEF_W-1:0] C_0304  = 29'd130567006;
  localparam logic [COEF_W-1:0] C_062   = 29'd266287972;
  localparam logic [COEF_W-1:0] C_0224  = 29'd96207267;
  localparam logic [COEF_W-1:0] C_031   = 29'd133143986;
  localparam logic [COEF_W-1:0] C_0128  = 29'd54975581;
  localparam logic [COEF_W-1:0] C_0153  = 29'd65713000;
  localparam logic [COEF_W-1:0] C_00146 = 29'd6270652;
  localparam logic [COEF_W-1:0] C_00112 = 29'd4810363;

  typedef enum logic [REG_W-1:0] {
    RGN_LOW  = 3'd0,
    RGN_MID  = 3'd1,
    RGN_HIGH = 3'd2,
    RGN_TOP  = 3'd3,
    RGN_OFF  = 3'd4
  } region_t;

  // one request moving down the divider row
  typedef struct packed {
    logic              valid;
    logic [CNT_W-1:0]  bb;
    logic [CNT_W-1:0]  ir;
    region_t           region;
    logic [CNT_W-1:0]  rem;
    logic              nbit;
    logic [Q_W-1:0]    quo;
  } div_t;

  typedef logic [TBL_W-1:0] pow_arr_t [POWER_TABLE_DEPTH+1];

  // T[i] = floor(i*2^16/(2D)) * u >> 12, u = Q12 of r^0.4 by integer 5th root of w^2
  function automatic pow_arr_t pow_table_f();
    pow_arr_t        t;
    longint unsigned w, sq, lo, hi, mid, p5, v;
    for (int i = 0; i <= POWER_TABLE_DEPTH; i++) begin
      w  = (longint'(i) << 30) / M_VAL;
      sq = w * w;
      lo = 0;
      hi = 4095;
      for (int k = 0; k < 13; k++) begin
        if (lo < hi) begin
          mid = (lo + hi + 1) >> 1;
          p5  = mid * mid * mid * mid * mid;
          if (p5 <= sq) lo = mid;
          else hi = mid - 1;
        end
      end
      v    = (((longint'(i) << 16) / M_VAL) * lo) >> 12;
      t[i] = v[TBL_W-1:0];
    end
    return t;
  endfunction

  localparam pow_arr_t POW_TABLE = pow_table_f();

endpackage
`default_nettype wire

[design/lcx_div_cell.sv]
// One restoring-division cell: produces one quotient bit and passes the request on.
`default_nettype none
module lcx_div_cell (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire lcx_pkg::div_t d_in,
  output lcx_pkg::div_t      d_out
);
  import lcx_pkg::*;

  logic [CNT_W:0]   trial;
  logic             qbit;
  div_t             d_nxt;
  div_t             d_r;

  // shift in one dividend bit, subtract when it fits
  always_comb begin
    trial = {d_in.rem, d_in.nbit};
    qbit  = (trial >= {1'b0, d_in.bb});
    d_nxt = d_in;
    d_nxt.rem  = qbit ? CNT_W'(trial - {1'b0, d_in.bb}) : trial[CNT_W-1:0];
    d_nxt.nbit = 1'b0;
    d_nxt.quo  = {d_in.quo[Q_W-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r.valid <= 1'b0;
    end else begin
      d_r.valid <= d_nxt.valid;
    end
    d_r.bb     <= d_nxt.bb;
    d_r.ir     <= d_nxt.ir;
    d_r.region <= d_nxt.region;
    d_r.rem    <= d_nxt.rem;
    d_r.nbit   <= d_nxt.nbit;
    d_r.quo    <= d_nxt.quo;
  end

  assign d_out = d_r;
endmodule
`default_nettype wire

[design/lcx_lux_back.sv]
// Back end: table interpolation, coefficient products and clamped lux.
`default_nettype none
module lcx_lux_back (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire lcx_pkg::div_t              d_in,
  output logic                            out_valid,
  output logic [lcx_pkg::LUX_W-1:0]       out_lux_value,
  output logic [lcx_pkg::REG_W-1:0]       out_ratio_region
);
  import lcx_pkg::*;

  // stage 1: segment and fraction, table reads
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] seg_full;
  logic [SEG_W-1:0] seg;
  logic             at_end;
  logic [TBL_W-1:0] t0_nxt, dif_nxt;
  logic [15:0]      frac_nxt;

  logic             v1_r;
  logic [CNT_W-1:0] bb1_r, ir1_r;
  region_t          rg1_r;
  logic [TBL_W-1:0] t0_1_r, dif1_r;
  logic [15:0]      frac1_r;

  always_comb begin
    pos      = POS_W'(d_in.quo) * POS_W'(M_VAL);
    seg_full = pos >> 16;
    at_end   = (seg_full >= POS_W'(POWER_TABLE_DEPTH));
    seg      = seg_full[SEG_W-1:0];
    frac_nxt = pos[15:0];
    if (at_end) begin
      t0_nxt  = POW_TABLE[POWER_TABLE_DEPTH];
      dif_nxt = '0;
    end else begin
      t0_nxt  = POW_TABLE[seg];
      dif_nxt = POW_TABLE[SEG_W'(seg + 1'b1)] - POW_TABLE[seg];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else v1_r <= d_in.valid;
    bb1_r   <= d_in.bb;
    ir1_r   <= d_in.ir;
    rg1_r   <= d_in.region;
    t0_1_r  <= t0_nxt;
    dif1_r  <= dif_nxt;
    frac1_r <= frac_nxt;
  end

  // stage 2: slope times fraction
  logic             v2_r;
  logic [CNT_W-1:0] bb2_r, ir2_r;
  region_t          rg2_r;
  logic [TBL_W-1:0] t0_2_r;
  logic [TBL_W+15:0] ip2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else v2_r <= v1_r;
    bb2_r  <= bb1_r;
    ir2_r  <= ir1_r;
    rg2_r  <= rg1_r;
    t0_2_r <= t0_1_r;
    ip2_r  <= (TBL_W+16)'(dif1_r) * (TBL_W+16)'(frac1_r);
  end

  // stage 3: interpolated power term
  logic             v3_r;
  logic [CNT_W-1:0] bb3_r, ir3_r;
  region_t          rg3_r;
  logic [TBL_W-1:0] p3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else v3_r <= v2_r;
    bb3_r <= bb2_r;
    ir3_r <= ir2_r;
    rg3_r <= rg2_r;
    p3_r  <= t0_2_r + ip2_r[TBL_W+15:16];
  end

  // stage 4: broadband times power term
  logic             v4_r;
  logic [CNT_W-1:0] bb4_r, ir4_r;
  region_t          rg4_r;
  logic [BBP_W-1:0] bbp4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else v4_r <= v3_r;
    bb4_r  <= bb3_r;
    ir4_r  <= ir3_r;
    rg4_r  <= rg3_r;
    bbp4_r <= BBP_W'(bb3_r) * BBP_W'(p3_r);
  end

  // stage 5: weighted terms per region
  logic [COEF_W-1:0] ca, cb;
  logic [PROD_W-1:0] b0_full;
  logic [PROD_W-1:0] a_nxt, b_nxt;
  logic              v5_r;
  region_t           rg5_r;
  logic [PROD_W-1:0] a5_r, b5_r;

  always_comb begin
    unique case (rg4_r)
      RGN_LOW:  begin ca = C_0304;  cb = '0;      end
      RGN_MID:  begin ca = C_0224;  cb = C_031;   end
      RGN_HIGH: begin ca = C_0128;  cb = C_0153;  end
      RGN_TOP:  begin ca = C_00146; cb = C_00112; end
      default:  begin ca = '0;      cb = '0;      end
    endcase
    b0_full = PROD_W'((64'(C_062) * 64'(bbp4_r)) >> 16);
    a_nxt   = PROD_W'(ca) * PROD_W'(bb4_r);
    b_nxt   = (rg4_r == RGN_LOW) ? b0_full : PROD_W'(cb) * PROD_W'(ir4_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else v5_r <= v4_r;
    rg5_r <= rg4_r;
    a5_r  <= a_nxt;
    b5_r  <= b_nxt;
  end

  // stage 6: difference, clamp, scale, saturate
  logic [PROD_W-1:0] dsh;
  logic [LUX_W-1:0]  lux_nxt;
  logic              v6_r;
  logic [LUX_W-1:0]  lux6_r;
  logic [REG_W-1:0]  rg6_r;

  always_comb begin
    dsh = (a5_r - b5_r) >> SHIFT;
    if (b5_r >= a5_r) lux_nxt = '0;
    else if (dsh > PROD_W'(LUX_MAX)) lux_nxt = LUX_MAX;
    else lux_nxt = dsh[LUX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v6_r <= 1'b0;
    else v6_r <= v5_r;
    lux6_r <= lux_nxt;
    rg6_r  <= rg5_r;
  end

  assign out_valid        = v6_r;
  assign out_lux_value    = lux6_r;
  assign out_ratio_region = rg6_r;
endmodule
`default_nettype wire

[design/two_channel_lux_calculator.sv]
// Top level: region select, divider row and lux back end.
// Takes one count pair per clock whenever start is high; busy stays low, so a
// request is taken in every cycle that start is high. Each result appears for
// one cycle with out_valid after it has passed one input register, 17 divider
// cells (one quotient bit each) and 6 back-end stages for interpolation,
// products and clamping. The receiver cannot stall the block and must take
// every strobe as it comes.
`default_nettype none
module two_channel_lux_calculator (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [lcx_pkg::CNT_W-1:0]  in_broadband_count,
  input  wire logic [lcx_pkg::CNT_W-1:0]  in_infrared_count,
  output logic                            out_valid,
  output logic [lcx_pkg::LUX_W-1:0]       out_lux_value,
  output logic [lcx_pkg::REG_W-1:0]       out_ratio_region
);
  import lcx_pkg::*;

  logic [CNT_W+6:0] bb_x, ir_x;
  region_t          rg_nxt;
  div_t             in_nxt;
  div_t             in_r;
  div_t             chain [DIV_CELLS+1];

  assign busy = 1'b0;

  // region by exact cross-multiplication
  always_comb begin
    bb_x = (CNT_W+7)'(in_broadband_count);
    ir_x = (CNT_W+7)'(in_infrared_count);
    if (in_broadband_count == '0)
      rg_nxt = (in_infrared_count == '0) ? RGN_LOW : RGN_OFF;
    else if (ir_x * 2 <= bb_x) rg_nxt = RGN_LOW;
    else if (ir_x * 100 <= bb_x * 61) rg_nxt = RGN_MID;
    else if (ir_x * 5 <= bb_x * 4) rg_nxt = RGN_HIGH;
    else if (ir_x * 10 <= bb_x * 13) rg_nxt = RGN_TOP;
    else rg_nxt = RGN_OFF;
    in_nxt.valid  = start;
    in_nxt.bb     = in_broadband_count;
    in_nxt.ir     = in_infrared_count;
    in_nxt.region = rg_nxt;
    in_nxt.rem    = in_infrared_count >> 1;
    in_nxt.nbit   = in_infrared_count[0];
    in_nxt.quo    = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) in_r.valid <= 1'b0;
    else in_r.valid <= in_nxt.valid;
    in_r.bb     <= in_nxt.bb;
    in_r.ir     <= in_nxt.ir;
    in_r.region <= in_nxt.region;
    in_r.rem    <= in_nxt.rem;
    in_r.nbit   <= in_nxt.nbit;
    in_r.quo    <= in_nxt.quo;
  end

  // divider row: one quotient bit per cell
  assign chain[0] = in_r;
  for (genvar k = 0; k < DIV_CELLS; k++) begin : g_div
    lcx_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .d_in  (chain[k]),
      .d_out (chain[k+1])
    );
  end

  lcx_lux_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .d_in             (chain[DIV_CELLS]),
    .out_valid        (out_valid),
    .out_lux_value    (out_lux_value),
    .out_ratio_region (out_ratio_region)
  );
endmodule
`default_nettype wire

[sim/tb_two_channel_lux_calculator.sv]
// Testbench for the two-channel lux calculator: directed table plus random pairs.
`timescale 1ns / 100ps
module tb_two_channel_lux_calculator;
  import lcx_pkg::*;

  localparam int N_RANDOM   = 1800;
  localparam int QUIET_TAIL = 300;
  localparam int N_DIRECTED = 22;

  typedef struct packed {
    logic [LUX_W-1:0] lux;
    region_t          region;
  } lux_res_t;

  typedef struct packed {
    logic [CNT_W-1:0] bb;
    logic [CNT_W-1:0] ir;
    logic             typed;
    lux_res_t         res;
  } dir_row_t;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  logic [CNT_W-1:0] in_broadband_count;
  logic [CNT_W-1:0] in_infrared_count;
  logic             out_valid;
  logic [LUX_W-1:0] out_lux_value;
  logic [REG_W-1:0] out_ratio_region;

  lux_res_t        lux_expected_q[$];
  int              mismatches = 0;
  longint unsigned ratio_pow14[POWER_TABLE_DEPTH+1];
  dir_row_t        dir_rows[N_DIRECTED];
  logic            typed_next;
  lux_res_t        typed_res;

  two_channel_lux_calculator i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_broadband_count(in_broadband_count),
    .in_infrared_count (in_infrared_count),
    .out_valid         (out_valid),
    .out_lux_value     (out_lux_value),
    .out_ratio_region  (out_ratio_region)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Q16 ratio^1.4 nodes, node i at ratio i/(2D)
  task automatic build_pow_nodes();
    longint unsigned span, w, sq, lo, hi, mid;
    span = 2 * POWER_TABLE_DEPTH;
    for (int i = 0; i <= POWER_TABLE_DEPTH; i++) begin
      w  = (longint'(i) << 30) / span;
      sq = w * w;
      lo = 0;
      hi = 4095;
      while (lo < hi) begin
        mid = (lo + hi + 1) >> 1;
        if (mid * mid * mid * mid * mid <= sq) lo = mid;
        else hi = mid - 1;
      end
      ratio_pow14[i] = (((longint'(i) << 16) / span) * lo) >> 12;
    end
  endtask

  // weighted difference, clamped at zero, saturated at the output width
  function automatic logic [LUX_W-1:0] clamp_lux(longint unsigned a, longint unsigned b);
    longint unsigned v;
    if (b >= a) return '0;
    v = (a - b) >> (32 - LUX_FRACTION_BITS);
    if (v > longint'(LUX_MAX)) return LUX_MAX;
    return v[LUX_W-1:0];
  endfunction

  function automatic lux_res_t predict_lux(logic [CNT_W-1:0] bb_in, logic [CNT_W-1:0] ir_in);
    lux_res_t        r;
    longint unsigned bb, ir, rq, pos, seg, frac, p;
    bb = bb_in;
    ir = ir_in;
    r.lux = '0;
    if (bb == 0) begin
      r.region = (ir == 0) ? RGN_LOW : RGN_OFF;
    end else if (2 * ir <= bb) begin
      rq   = (ir << 16) / bb;
      pos  = rq * 2 * POWER_TABLE_DEPTH;
      seg  = pos >> 16;
      frac = pos & 64'hFFFF;
      if (seg >= POWER_TABLE_DEPTH) p = ratio_pow14[POWER_TABLE_DEPTH];
      else p = ratio_pow14[seg] + (((ratio_pow14[seg+1] - ratio_pow14[seg]) * frac) >> 16);
      r.region = RGN_LOW;
      r.lux = clamp_lux(longint'(C_0304) * bb, (longint'(C_062) * bb * p) >> 16);
    end else if (100 * ir <= 61 * bb) begin
      r.region = RGN_MID;
      r.lux = clamp_lux(longint'(C_0224) * bb, longint'(C_031) * ir);
    end else if (5 * ir <= 4 * bb) begin
      r.region = RGN_HIGH;
      r.lux = clamp_lux(longint'(C_0128) * bb, longint'(C_0153) * ir);
    end else if (10 * ir <= 13 * bb) begin
      r.region = RGN_TOP;
      r.lux = clamp_lux(longint'(C_00146) * bb, longint'(C_00112) * ir);
    end else begin
      r.region = RGN_OFF;
    end
    return r;
  endfunction

  // random pair, mostly steered into one region
  task automatic pick_pair(output logic [CNT_W-1:0] bb, output logic [CNT_W-1:0] ir);
    int unsigned k, b, i;
    k = $urandom_range(0, 9);
    b = (k < 2) ? $urandom_range(1, 300) : $urandom_range(1, 65535);
    case (k)
      0, 1: i = $urandom_range(0, b * 2);
      2:    i = $urandom_range(0, b / 2);
      3:    i = b * $urandom_range(50, 61) / 100 + $urandom_range(0, 1);
      4:    i = b * $urandom_range(61, 80) / 100 + $urandom_range(0, 1);
      5:    i = b * $urandom_range(80, 130) / 100 + $urandom_range(0, 1);
      6:    i = b * $urandom_range(130, 200) / 100 + $urandom_range(0, 1);
      7:    i = $urandom_range(0, 65535);
      default: i = $urandom_range(0, b);
    endcase
    if (i > 65535) i = 65535;
    bb = b[CNT_W-1:0];
    ir = i[CNT_W-1:0];
    if ($urandom_range(0, 40) == 0) bb = '0;
  endtask

  // log each accepted request's expectation, check each strobe
  always @(posedge clk) begin
    lux_res_t e;
    if (rst_n && start && !busy) begin
      e = predict_lux(in_broadband_count, in_infrared_count);
      if (typed_next) e = typed_res;
      lux_expected_q.push_back(e);
    end
    if (rst_n && out_valid) begin
      if (lux_expected_q.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected result lux=%0d region=%0d",
                                      out_lux_value, out_ratio_region);
      end else begin
        e = lux_expected_q.pop_front();
        if (out_lux_value !== e.lux || out_ratio_region !== e.region) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("mismatch: exp lux=%0d region=%0d, got lux=%0d region=%0d",
                     e.lux, e.region, out_lux_value, out_ratio_region);
        end
      end
    end
  end

  task automatic send_pair(logic [CNT_W-1:0] bb, logic [CNT_W-1:0] ir, bit may_idle);
    int gap;
    if (may_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start              <= 1'b1;
    in_broadband_count <= bb;
    in_infrared_count  <= ir;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  initial begin
    logic [CNT_W-1:0] bb, ir;
    int               waited;
    typed_next         <= 1'b0;
    typed_res          <= '0;
    rst_n              <= 1'b0;
    start              <= 1'b0;
    in_broadband_count <= '0;
    in_infrared_count  <= '0;
    build_pow_nodes();

    // directed rows: typed where the answer is plain
    dir_rows[0]  = '{16'd0, 16'd0, 1'b1, '{'0, RGN_LOW}};
    dir_rows[1]  = '{16'd0, 16'd1, 1'b1, '{'0, RGN_OFF}};
    dir_rows[2]  = '{16'd0, 16'hFFFF, 1'b1, '{'0, RGN_OFF}};
    dir_rows[3]  = '{16'd1, 16'hFFFF, 1'b1, '{'0, RGN_OFF}};
    dir_rows[4]  = '{16'd100, 16'd131, 1'b1, '{'0, RGN_OFF}};
    dir_rows[5]  = '{16'hFFFF, 16'd0, 1'b0, '0};
    dir_rows[6]  = '{16'd1, 16'd0, 1'b0, '0};
    dir_rows[7]  = '{16'd1, 16'd1, 1'b0, '0};
    dir_rows[8]  = '{16'hFFFF, 16'hFFFF, 1'b0, '0};
    dir_rows[9]  = '{16'd200, 16'd100, 1'b0, '0};
    dir_rows[10] = '{16'd200, 16'd101, 1'b0, '0};
    dir_rows[11] = '{16'd100, 16'd61, 1'b0, '0};
    dir_rows[12] = '{16'd100, 16'd62, 1'b0, '0};
    dir_rows[13] = '{16'd100, 16'd80, 1'b0, '0};
    dir_rows[14] = '{16'd100, 16'd81, 1'b0, '0};
    dir_rows[15] = '{16'd100, 16'd130, 1'b0, '0};
    dir_rows[16] = '{16'hFFFF, 16'h7FFF, 1'b0, '0};
    dir_rows[17] = '{16'hFFFF, 16'h8000, 1'b0, '0};
    dir_rows[18] = '{16'hFFFF, 16'd1, 1'b0, '0};
    dir_rows[19] = '{16'h5555, 16'h2AAA, 1'b0, '0};
    dir_rows[20] = '{16'hAAAA, 16'h5555, 1'b0, '0};
    dir_rows[21] = '{16'h8000, 16'h0001, 1'b0, '0};

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int n = 0; n < N_DIRECTED; n++) begin
      typed_next <= dir_rows[n].typed;
      typed_res  <= dir_rows[n].res;
      send_pair(dir_rows[n].bb, dir_rows[n].ir, 1'b1);
    end
    typed_next <= 1'b0;

    for (int n = 0; n < N_RANDOM; n++) begin
      // drain once mid-run before sending more
      if (n == N_RANDOM / 2) begin
        start <= 1'b0;
        @(posedge clk);
        while (lux_expected_q.size() != 0) @(posedge clk);
      end
      pick_pair(bb, ir);
      send_pair(bb, ir, n < N_RANDOM - QUIET_TAIL);
    end
    start <= 1'b0;

    waited = 0;
    while (lux_expected_q.size() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (30) @(posedge clk);
    if (mismatches == 0 && lux_expected_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // hard stop
  initial begin
    #(8 * 400000);
    $display("CHECK FAILED");
    $finish;
  end

endmodule

[files.f]
design/lcx_pkg.sv
design/lcx_div_cell.sv
design/lcx_lux_back.sv
design/two_channel_lux_calculator.sv
sim/tb_two_channel_lux_calculator.sv
